>>> hdl/shash_pkg.sv
// ----------------------------------------------------------------------------
// shash_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shash_pkg;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
   } req_type;

   // result word
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       write_byte;
      logic       load_vars;
      logic       round;
      logic [5:0] round_idx;
      logic       update;
      logic       pad_first;
      logic       pad_second;
      logic       load_out;
      logic [2:0] word_idx;
      logic       reinit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pos_last;
      logic pos_high;
      logic out_free;
   } stat_type;

   localparam int unsigned CountWidth = 61;
   localparam logic [7:0]  PadMark    = 8'h80;

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] r;
      case (i)
         6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491;
         6'd2: r = 32'hb5c0fbcf; 6'd3: r = 32'he9b5dba5;
         6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5;
         6'd8: r = 32'hd807aa98; 6'd9: r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;
         default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

>>> hdl/shash_ctrl.sv
// ----------------------------------------------------------------------------
// shash_ctrl
// Sequencer: byte intake, 64-round compression, padding and digest output.
// ----------------------------------------------------------------------------
module shash_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  shash_pkg::req_type req_data,
   input  shash_pkg::stat_type stat,
   output shash_pkg::cmd_type cmd
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StRound  = 3'd1;
   localparam logic [2:0] StUpdate = 3'd2;
   localparam logic [2:0] StPad1   = 3'd3;
   localparam logic [2:0] StPad2   = 3'd4;
   localparam logic [2:0] StEmit   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] after_ff, after_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;
   logic       accept;

   assign req_stall = (state_ff != StIdle);
   assign accept    = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.round_idx = rnd_ff;
      cmd.word_idx  = idx_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               cmd.write_byte = req_data.byte_valid;
               if (req_data.byte_valid && stat.pos_last) begin
                  cmd.load_vars = 1'b1;
                  rnd_in   = '0;
                  state_in = StRound;
                  after_in = req_data.last_byte ? StPad1 : StIdle;
               end else if (req_data.last_byte) begin
                  state_in = StPad1;
               end
            end
         end
         StRound: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = StUpdate;
            end
         end
         StUpdate: begin
            cmd.update = 1'b1;
            idx_in     = '0;
            state_in   = after_ff;
         end
         StPad1: begin
            cmd.pad_first = 1'b1;
            cmd.load_vars = 1'b1;
            rnd_in   = '0;
            state_in = StRound;
            after_in = stat.pos_high ? StPad2 : StEmit;
         end
         StPad2: begin
            cmd.pad_second = 1'b1;
            cmd.load_vars  = 1'b1;
            rnd_in   = '0;
            state_in = StRound;
            after_in = StEmit;
         end
         StEmit: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               idx_in       = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.reinit = 1'b1;
                  state_in   = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         after_ff <= StIdle;
         rnd_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

>>> hdl/shash_dp.sv
// ----------------------------------------------------------------------------
// shash_dp
// Block buffer and schedule window, round registers, chain value and output.
// ----------------------------------------------------------------------------
module shash_dp (
   input  logic                clock,
   input  logic                reset,
   input  shash_pkg::req_type  req_data,
   input  shash_pkg::cmd_type  cmd,
   output shash_pkg::stat_type stat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output shash_pkg::rsp_type  rsp_data
);

   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] var_ff [8];
   logic [31:0] var_in [8];
   logic [31:0] chain_ff [8];
   logic [shash_pkg::CountWidth-1:0] count_ff;
   logic [5:0]  pos;
   logic [63:0] bit_len;
   logic [31:0] w_next, t1, t2, s0, s1, ss0, ss1, ch, maj;
   logic        rsp_valid_ff;
   shash_pkg::rsp_type rsp_ff;

   assign pos     = count_ff[5:0];
   assign bit_len = {count_ff, 3'b000};

   assign stat.pos_last = (pos == 6'd63);
   assign stat.pos_high = (pos[5:3] == 3'b111);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   // schedule expansion
   assign s0 = shash_pkg::rotr(win_ff[1], 7) ^ shash_pkg::rotr(win_ff[1], 18)
             ^ (win_ff[1] >> 3);
   assign s1 = shash_pkg::rotr(win_ff[14], 17) ^ shash_pkg::rotr(win_ff[14], 19)
             ^ (win_ff[14] >> 10);
   assign w_next = s1 + win_ff[9] + s0 + win_ff[0];

   // round logic
   assign ss1 = shash_pkg::rotr(var_ff[4], 6) ^ shash_pkg::rotr(var_ff[4], 11)
              ^ shash_pkg::rotr(var_ff[4], 25);
   assign ss0 = shash_pkg::rotr(var_ff[0], 2) ^ shash_pkg::rotr(var_ff[0], 13)
              ^ shash_pkg::rotr(var_ff[0], 22);
   assign ch  = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2])
              ^ (var_ff[1] & var_ff[2]);
   assign t1  = var_ff[7] + ss1 + ch + shash_pkg::round_k(cmd.round_idx) + win_ff[0];
   assign t2  = ss0 + maj;

   // buffer window next value
   always_comb begin
      for (int j = 0; j < 16; j++) begin
         win_in[j] = win_ff[j];
      end
      if (cmd.round) begin
         for (int j = 0; j < 15; j++) begin
            win_in[j] = win_ff[j+1];
         end
         win_in[15] = w_next;
      end else if (cmd.write_byte) begin
         win_in[pos[5:2]][31-8*pos[1:0] -: 8] = req_data.data_byte;
      end else if (cmd.pad_first || cmd.pad_second) begin
         for (int j = 0; j < 16; j++) begin
            for (int b = 0; b < 4; b++) begin
               if (cmd.pad_second || (6'(4*j+b) > pos)) begin
                  win_in[j][31-8*b -: 8] = 8'h00;
               end else if (6'(4*j+b) == pos) begin
                  win_in[j][31-8*b -: 8] = shash_pkg::PadMark;
               end
            end
         end
         if (cmd.pad_second || !stat.pos_high) begin
            win_in[14] = bit_len[63:32];
            win_in[15] = bit_len[31:0];
         end
      end
   end

   // working variables next value
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         var_in[i] = var_ff[i];
      end
      if (cmd.load_vars) begin
         for (int i = 0; i < 8; i++) begin
            var_in[i] = chain_ff[i];
         end
      end else if (cmd.round) begin
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      for (int j = 0; j < 16; j++) begin
         win_ff[j] <= win_in[j];
      end
      for (int i = 0; i < 8; i++) begin
         var_ff[i] <= var_in[i];
      end
      if (cmd.load_out) begin
         rsp_ff.digest_word <= chain_ff[cmd.word_idx];
         rsp_ff.word_index  <= cmd.word_idx;
         rsp_ff.last_word   <= (cmd.word_idx == 3'd7);
      end
   end

   // chain value, byte count and output valid
   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= shash_pkg::init_hash(3'(i));
         end
         count_ff <= '0;
      end else begin
         if (cmd.update) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + var_ff[i];
            end
         end
         if (cmd.write_byte) begin
            count_ff <= count_ff + 1'b1;
         end
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/sha256_stream_hasher_unit.sv
// a byte that does not fill a block is taken without stalling the input
// a byte that fills a block stalls the input while the single round unit runs
// the 64 rounds and then the chain update
// a last item adds one or two padding compressions and eight output words
// reset restores the initial hash value and a zero byte count
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 over a byte stream, digest returned as eight 32-bit words.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  shash_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output shash_pkg::rsp_type rsp_data
);

   shash_pkg::cmd_type  cmd;
   shash_pkg::stat_type stat;

   // sequencer
   shash_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   shash_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sha256_stream_hasher_unit_test.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit_test
// Drives byte streams into the SHA-256 hasher with random idling on both
// channels and checks every digest word against an in-bench SHA-256 model.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit_test;

   localparam int unsigned CycleLimit = 1500000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   shash_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   shash_pkg::rsp_type rsp_data;

   sha256_stream_hasher_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // hash model state
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [60:0] msg_len;
   shash_pkg::rsp_type digest_queue [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] iv_word(int unsigned i);
      logic [31:0] iv [8];
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return iv[i];
   endfunction

   function automatic logic [31:0] k_word(int unsigned i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
         32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
         32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
         32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
         32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
         32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
         32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
         32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
         32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   // one 64-round compression of msg_block into hash_state
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_word(i) + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic reset_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = iv_word(i);
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      msg_len = '0;
   endtask

   // absorb one accepted word, pad and queue the digest on last
   task automatic absorb_word(shash_pkg::req_type r);
      int unsigned pos;
      logic [63:0] bits;
      shash_pkg::rsp_type e;
      if (r.byte_valid) begin
         pos = msg_len[5:0];
         msg_block[pos] = r.data_byte;
         msg_len = msg_len + 1'b1;
         if (pos == 63) compress_block();
      end
      if (r.last_byte) begin
         pos = msg_len[5:0];
         msg_block[pos] = 8'h80;
         for (int i = pos + 1; i < 64; i++) msg_block[i] = 8'h00;
         if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
         end
         bits = {msg_len, 3'b000};
         for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            e.digest_word = hash_state[i];
            e.word_index  = 3'(i);
            e.last_word   = (i == 7);
            digest_queue.push_back(e);
         end
         for (int i = 0; i < 8; i++) hash_state[i] = iv_word(i);
         msg_len = '0;
      end
   endtask

   task automatic report_mismatch(string what, shash_pkg::rsp_type e,
                                  shash_pkg::rsp_type a);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %h/%0d/%0d got %h/%0d/%0d", what,
                  e.digest_word, e.word_index, e.last_word,
                  a.digest_word, a.word_index, a.last_word);
   endtask

   // send one word, idling before it at the sender rate
   // valid stays high after the accept until the next call or a drain wait
   task automatic send_word(logic [7:0] b, logic bv, logic lb);
      shash_pkg::req_type r;
      r.data_byte  = b;
      r.byte_valid = bv;
      r.last_byte  = lb;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_word(r);
   endtask

   // random message of the given length, bytes then last (maybe fused)
   task automatic send_message(int unsigned len);
      logic fuse;
      fuse = (len > 0) && $urandom_range(1);
      for (int i = 0; i < len; i++)
         send_word(8'($urandom), 1'b1, fuse && (i == len - 1));
      if (!fuse) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   // sender goes quiet until every expected word is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // receiver side: random stall and result check
   always @(posedge clock) begin
      shash_pkg::rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               report_mismatch("unexpected", '0, rsp_data);
            end else begin
               e = digest_queue.pop_front();
               if (rsp_data !== e) report_mismatch("digest", e, rsp_data);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("** sha256_stream_hasher_unit: FAILED **");
         $finish;
      end
   end

   // directed table: data, byte valid, last
   typedef struct {
      logic [7:0] b;
      logic       bv;
      logic       lb;
   } dir_row_type;

   initial begin
      dir_row_type dir_rows [$];
      int unsigned len;
      shash_pkg::rsp_type e0;
      send_idle_pct  = 15;
      recv_idle_pct  = 70;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      reset_hash();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty message right after reset, digest known by heart
      send_word(8'h00, 1'b0, 1'b1);
      e0 = digest_queue[0];
      if (e0.digest_word !== 32'he3b0c442) report_mismatch("empty", e0, e0);
      wait_drained();

      // idle word, "abc" with fused last, 0x00 and 0xff with lone last, idle word, empty message
      dir_rows = '{'{8'h5a, 1'b0, 1'b0}, '{8'h61, 1'b1, 1'b0}, '{8'h62, 1'b1, 1'b0},
                   '{8'h63, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b0}, '{8'hff, 1'b1, 1'b0},
                   '{8'hff, 1'b0, 1'b1}, '{8'hff, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1}};
      foreach (dir_rows[i]) send_word(dir_rows[i].b, dir_rows[i].bv, dir_rows[i].lb);
      wait_drained();

      // padding boundaries: 55, 56 and 64 bytes
      send_message(55);
      send_message(56);
      send_message(64);
      wait_drained();

      // random messages across three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 70 : 0;
         recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 15 : 0;
         for (int m = 0; m < 8; m++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
            if ($urandom_range(5) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_message(len);
            if (m == 3) wait_drained();
         end
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && digest_queue.size() == 0)
         $display("** sha256_stream_hasher_unit: PASSED **");
      else
         $display("** sha256_stream_hasher_unit: FAILED **");
      $finish;
   end

endmodule
